// ----- hw/rtl/lhist_pkg.sv -----
// Shared widths, codes and a helper function for the log2 latency histogram.
package lhist_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int FRAC_W     = 17;
  localparam int FRAC_LO_W  = 16;
  localparam int SUM_W      = 64;
  localparam int OUT_CNT_W  = 32;
  localparam int PCT_W      = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 192;
  localparam int LOG2_W     = 5;
  localparam int WIDE_IDX_W = 6;
  localparam int PCT_TOP    = 31;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Position of the highest set bit; zero maps to bucket 0.
  function automatic logic [LOG2_W-1:0] floor_log2(input logic [SAMPLE_W-1:0] v);
    logic [LOG2_W-1:0] k;
    k = '0;
    for (int i = 1; i < SAMPLE_W; i++) begin
      if (v[i]) begin
        k = LOG2_W'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- hw/rtl/lhist_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lhist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/log2_latency_histogram_top.sv -----
// Top level of the log2 latency histogram: sequencer, shared adder and bucket RAM.
//
// Usage: each in_ transaction carries one item. in_tuser selects the kind:
// 0 adds in_tdata[31:0] as a nanosecond sample, 1 queries the percentile
// in_tdata[48:32] (Q1.16, 65536 = 1.0). Every item gives exactly one out_
// transaction with count, min, max, 64-bit sum and the percentile bucket.
// An add reads its bucket from the RAM, does the read-modify-write, then
// loads the output register and raises out_tvalid. A query runs a
// shift-add multiply for the target and rounds it up, walks the buckets
// (RAM read, then accumulate, per bucket) and loads the output; a fraction
// of one or more skips the multiply and the rounding, and an empty
// histogram goes straight to loading the output. The sample sum, the
// multiply, the rounding and the walk's accumulation share one 64-bit
// adder, and the single bucket RAM read port gives each walked bucket a
// read state and an accumulate state. One item is in work at a time;
// in_tready is high only while idle, so the next item can be accepted in
// the same cycle as out_tvalid rises at the earliest. A stalled receiver
// holds the result, and a finished item waits until out_tready frees the
// register. Reset clears all counters and the per-bucket valid bits at
// once, so the block is usable as soon as reset is released.
module log2_latency_histogram_top #(
  parameter int NUM_BUCKETS = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: sample_ns[31:0], fraction_q16[48:32], zero fill [55:49]
  input  logic [lhist_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: sample_count[31:0], min_ns[63:32], max_ns[95:64],
  // sum_ns[159:96], percentile_ns[191:160]
  output logic [lhist_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int BW     = $clog2(NUM_BUCKETS);
  localparam int STEP_W = $clog2(lhist_pkg::FRAC_LO_W);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_RD = 3'd1;
  localparam logic [2:0] S_ADD_WR = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_TGT    = 3'd4;
  localparam logic [2:0] S_Q_RD   = 3'd5;
  localparam logic [2:0] S_Q_ACC  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam logic [BW-1:0]          LAST_BUCKET = BW'(NUM_BUCKETS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX     = '1;

  // Control state.
  logic [2:0]                         state_r, state_nxt;
  logic [NUM_BUCKETS-1:0]             valid_r, valid_nxt;
  logic [COUNT_WIDTH-1:0]             total_r, total_nxt;
  logic [lhist_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [lhist_pkg::SAMPLE_W-1:0]     min_r, min_nxt;
  logic [lhist_pkg::SAMPLE_W-1:0]     max_r, max_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0]                  step_r, step_nxt;
  logic [BW-1:0]                      k_r, k_nxt;

  // Item payload and working registers.
  logic [lhist_pkg::SAMPLE_W-1:0]     sample_r, sample_nxt;
  logic [lhist_pkg::FRAC_LO_W-1:0]    frac_r, frac_nxt;
  logic [COUNT_WIDTH-1:0]             mul_hi_r, mul_hi_nxt;
  logic                               sticky_r, sticky_nxt;
  logic [COUNT_WIDTH-1:0]             target_r, target_nxt;
  logic [lhist_pkg::SUM_W-1:0]        acc_r, acc_nxt;
  logic [lhist_pkg::PCT_W-1:0]        pct_r, pct_nxt;
  logic [lhist_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  // Shared adder.
  logic [lhist_pkg::SUM_W-1:0]        add_a, add_b;
  logic [lhist_pkg::SUM_W:0]          add_s;

  // Bucket RAM.
  logic                               ram_we;
  logic [BW-1:0]                      ram_raddr;
  logic [COUNT_WIDTH-1:0]             ram_wdata, ram_rdata, bucket_val;

  logic                               in_fire;
  logic [lhist_pkg::WIDE_IDX_W-1:0]   log2_wide;
  logic [BW-1:0]                      add_idx;
  logic [lhist_pkg::SUM_W-1:0]        acc_sat;
  logic [lhist_pkg::WIDE_IDX_W-1:0]   k_wide;
  logic [lhist_pkg::PCT_W-1:0]        k_pow2;
  logic [lhist_pkg::OUT_CNT_W-1:0]    count_out;
  logic                               out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Bucket index of the held sample, clamped to the last bucket.
  assign log2_wide = lhist_pkg::WIDE_IDX_W'(lhist_pkg::floor_log2(sample_r));
  always_comb begin
    if (log2_wide > lhist_pkg::WIDE_IDX_W'(NUM_BUCKETS - 1)) begin
      add_idx = LAST_BUCKET;
    end else begin
      add_idx = log2_wide[BW-1:0];
    end
  end

  assign ram_raddr  = (state_r == S_ADD_RD) ? add_idx : k_r;
  assign bucket_val = valid_r[k_r] ? ram_rdata : '0;
  assign ram_we     = (state_r == S_ADD_WR);
  assign ram_wdata  = (bucket_val == CNT_MAX) ? bucket_val : bucket_val + 1'b1;

  lhist_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_BUCKETS)
  ) u_bucket_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(k_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Operand selection for the shared adder.
  always_comb begin
    unique case (state_r)
      S_ADD_WR: begin
        add_a = sum_r;
        add_b = lhist_pkg::SUM_W'(sample_r);
      end
      S_MUL: begin
        add_a = lhist_pkg::SUM_W'(mul_hi_r);
        add_b = frac_r[step_r] ? lhist_pkg::SUM_W'(total_r) : '0;
      end
      S_TGT: begin
        add_a = lhist_pkg::SUM_W'(mul_hi_r);
        add_b = lhist_pkg::SUM_W'(sticky_r);
      end
      S_Q_ACC: begin
        add_a = acc_r;
        add_b = lhist_pkg::SUM_W'(bucket_val);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_s   = {1'b0, add_a} + {1'b0, add_b};
  assign acc_sat = add_s[lhist_pkg::SUM_W] ? '1 : add_s[lhist_pkg::SUM_W-1:0];

  assign k_wide = lhist_pkg::WIDE_IDX_W'(k_r);
  assign k_pow2 = (k_wide > lhist_pkg::WIDE_IDX_W'(lhist_pkg::PCT_TOP))
                  ? (lhist_pkg::PCT_W'(1) << lhist_pkg::PCT_TOP)
                  : (lhist_pkg::PCT_W'(1) << k_wide);

  generate
    if (COUNT_WIDTH > lhist_pkg::OUT_CNT_W) begin : g_wide_count
      assign count_out = (|total_r[COUNT_WIDTH-1:lhist_pkg::OUT_CNT_W])
                         ? '1 : total_r[lhist_pkg::OUT_CNT_W-1:0];
    end else begin : g_narrow_count
      assign count_out = lhist_pkg::OUT_CNT_W'(total_r);
    end
  endgenerate

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    sample_nxt    = sample_r;
    frac_nxt      = frac_r;
    mul_hi_nxt    = mul_hi_r;
    sticky_nxt    = sticky_r;
    target_nxt    = target_r;
    acc_nxt       = acc_r;
    pct_nxt       = pct_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_nxt = in_tdata[lhist_pkg::SAMPLE_W-1:0];
          frac_nxt   = in_tdata[lhist_pkg::SAMPLE_W +: lhist_pkg::FRAC_LO_W];
          mul_hi_nxt = '0;
          sticky_nxt = 1'b0;
          step_nxt   = '0;
          acc_nxt    = '0;
          k_nxt      = '0;
          pct_nxt    = '0;
          target_nxt = total_r;
          if (in_tuser == lhist_pkg::MODE_ADD) begin
            state_nxt = S_ADD_RD;
          end else if (total_r == '0) begin
            state_nxt = S_DONE;
          end else if (in_tdata[lhist_pkg::SAMPLE_W + lhist_pkg::FRAC_W - 1]) begin
            // A fraction of one or more targets the whole count.
            state_nxt = S_Q_RD;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_ADD_RD: begin
        k_nxt     = add_idx;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        valid_nxt[k_r] = 1'b1;
        total_nxt = (total_r == CNT_MAX) ? total_r : total_r + 1'b1;
        sum_nxt   = add_s[lhist_pkg::SUM_W-1:0];
        if (sample_r < min_r) begin
          min_nxt = sample_r;
        end
        if (sample_r > max_r) begin
          max_nxt = sample_r;
        end
        state_nxt = S_DONE;
      end
      S_MUL: begin
        // LSB-first shift-add: keep the upper product bits and note whether
        // any bit shifted below the binary point was set.
        mul_hi_nxt = add_s[COUNT_WIDTH:1];
        sticky_nxt = sticky_r | add_s[0];
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(lhist_pkg::FRAC_LO_W - 1)) begin
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        if (add_s[COUNT_WIDTH-1:0] == '0) begin
          target_nxt = COUNT_WIDTH'(1);
        end else begin
          target_nxt = add_s[COUNT_WIDTH-1:0];
        end
        state_nxt = S_Q_RD;
      end
      S_Q_RD: begin
        state_nxt = S_Q_ACC;
      end
      S_Q_ACC: begin
        acc_nxt = acc_sat;
        if (acc_sat >= lhist_pkg::SUM_W'(target_r)) begin
          pct_nxt   = k_pow2;
          state_nxt = S_DONE;
        end else if (k_r == LAST_BUCKET) begin
          pct_nxt   = lhist_pkg::PCT_W'(1) << lhist_pkg::PCT_TOP;
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_Q_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {pct_r,
                           sum_r,
                           (total_r != '0) ? max_r : '0,
                           (total_r != '0) ? min_r : '0,
                           count_out};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      sum_r       <= '0;
      min_r       <= '1;
      max_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    frac_r     <= frac_nxt;
    mul_hi_r   <= mul_hi_nxt;
    sticky_r   <= sticky_nxt;
    target_r   <= target_nxt;
    acc_r      <= acc_nxt;
    pct_r      <= pct_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- dv/log2_latency_histogram_top_tb.sv -----
// Self-checking testbench for the log2 latency histogram: random stream traffic, scoreboard.
module log2_latency_histogram_top_tb;
  import lhist_pkg::*;

  localparam int NUM_BUCKETS  = 32;
  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam int IDLE_PCT     = 14;
  localparam int CALM_FROM    = 4000;
  localparam int CALM_TO      = 10000;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample_ns;
    logic [FRAC_W-1:0]   fraction_q16;
  } histogram_item_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] sample_count;
    logic [SAMPLE_W-1:0]  min_ns;
    logic [SAMPLE_W-1:0]  max_ns;
    logic [SUM_W-1:0]     sum_ns;
    logic [PCT_W-1:0]     percentile_ns;
  } histogram_stats_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = MODE_ADD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  histogram_item_t  pending_items[$];
  histogram_stats_t expected_stats[$];

  // Predicted histogram state.
  logic [OUT_CNT_W-1:0] bin_count[NUM_BUCKETS];
  logic [OUT_CNT_W-1:0] seen_count;
  logic [SUM_W-1:0]     seen_sum;
  logic [SAMPLE_W-1:0]  seen_min;
  logic [SAMPLE_W-1:0]  seen_max;

  logic in_taken     = 1'b0;
  int   cycle_count  = 0;
  int   quiet_cycles = 0;
  int   error_count  = 0;
  int   add_count    = 0;
  int   query_count  = 0;
  int   hit_queries  = 0;
  int   checked      = 0;

  log2_latency_histogram_top #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .COUNT_WIDTH(OUT_CNT_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one item to the predicted state and returns the statistics it reports.
  function automatic histogram_stats_t histogram_apply(histogram_item_t it);
    histogram_stats_t  res;
    int                bin;
    logic [FRAC_W-1:0] frac;
    logic [63:0]       target;
    logic [63:0]       running;
    bit                found;
    res = '0;
    if (it.mode == MODE_ADD) begin
      bin = (it.sample_ns == '0) ? 0 : $clog2({1'b0, it.sample_ns} + 33'd1) - 1;
      if (bin > NUM_BUCKETS - 1) begin
        bin = NUM_BUCKETS - 1;
      end
      if (bin_count[bin] != '1) begin
        bin_count[bin] = bin_count[bin] + 1'b1;
      end
      if (seen_count != '1) begin
        seen_count = seen_count + 1'b1;
      end
      seen_sum = seen_sum + SUM_W'(it.sample_ns);
      if (it.sample_ns < seen_min) begin
        seen_min = it.sample_ns;
      end
      if (it.sample_ns > seen_max) begin
        seen_max = it.sample_ns;
      end
    end else if (seen_count != '0) begin
      frac = (it.fraction_q16 > FRAC_ONE) ? FRAC_ONE : it.fraction_q16;
      // Ceiling of frac * count / 2^16; a full fraction gives the count itself.
      target = (64'(frac) * 64'(seen_count) + 64'hFFFF) >> 16;
      if (target == '0) begin
        target = 64'd1;
      end
      // Sums of 32-bit bucket counts cannot overflow 64 bits here.
      running = '0;
      found = 1'b0;
      res.percentile_ns = PCT_W'(1) << PCT_TOP;
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        running = running + 64'(bin_count[k]);
        if (!found && running >= target) begin
          found = 1'b1;
          res.percentile_ns = PCT_W'(1) << ((k > PCT_TOP) ? PCT_TOP : k);
        end
      end
    end
    res.sample_count = seen_count;
    res.min_ns       = (seen_count != '0) ? seen_min : '0;
    res.max_ns       = (seen_count != '0) ? seen_max : '0;
    res.sum_ns       = seen_sum;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic push_add(input logic [SAMPLE_W-1:0] ns, input logic [FRAC_W-1:0] frac);
    pending_items.push_back('{mode: MODE_ADD, sample_ns: ns, fraction_q16: frac});
  endtask

  task automatic push_query(input logic [FRAC_W-1:0] frac, input logic [SAMPLE_W-1:0] ns);
    pending_items.push_back('{mode: MODE_QUERY, sample_ns: ns, fraction_q16: frac});
  endtask

  // Driver: at the falling edge, offers pending items once the bus is free, with random gaps.
  always @(negedge clk) begin : driver
    histogram_item_t nxt;
    bit              calm;
    calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.mode;
          in_tdata  <= {{(IN_DATA_W - FRAC_W - SAMPLE_W){1'b0}}, nxt.fraction_q16,
                        nxt.sample_ns};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predicts on each input transaction and checks each output transaction.
  always @(posedge clk) begin : monitor
    histogram_item_t  seen_item;
    histogram_stats_t want;
    histogram_stats_t got;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        got = '{sample_count:  out_tdata[31:0],
                min_ns:        out_tdata[63:32],
                max_ns:        out_tdata[95:64],
                sum_ns:        out_tdata[159:96],
                percentile_ns: out_tdata[191:160]};
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_tdata);
          error_count++;
        end else begin
          want = expected_stats.pop_front();
          check_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
          check_field("min_ns", 64'(want.min_ns), 64'(got.min_ns));
          check_field("max_ns", 64'(want.max_ns), 64'(got.max_ns));
          check_field("sum_ns", want.sum_ns, got.sum_ns);
          check_field("percentile_ns", 64'(want.percentile_ns), 64'(got.percentile_ns));
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        seen_item.mode         = in_tuser;
        seen_item.sample_ns    = in_tdata[SAMPLE_W-1:0];
        seen_item.fraction_q16 = in_tdata[SAMPLE_W +: FRAC_W];
        want = histogram_apply(seen_item);
        expected_stats.push_back(want);
        if (seen_item.mode == MODE_ADD) begin
          add_count++;
        end else begin
          query_count++;
          if (want.percentile_ns != '0) begin
            hit_queries++;
          end
        end
      end
      in_taken     <= in_tvalid && in_tready;
      quiet_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ?
                      0 : quiet_cycles + 1;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] ns;
    logic [FRAC_W-1:0]   frac;
    int                  bin;

    for (int k = 0; k < NUM_BUCKETS; k++) begin
      bin_count[k] = '0;
    end
    seen_count = '0;
    seen_sum   = '0;
    seen_min   = '1;
    seen_max   = '0;

    // Directed part: empty histogram, range extremes, fraction corner values.
    push_query(FRAC_ONE, 32'h0);
    push_query(17'd0, 32'hFFFF_FFFF);
    push_add(32'h0, 17'h1FFFF);
    push_query(17'd0, 32'h0);
    push_add(32'h1, 17'h0);
    push_add(32'h2, 17'h0);
    push_add(32'hFFFF_FFFF, 17'h0);
    push_add(32'h8000_0000, 17'h0);
    push_add(32'h7FFF_FFFF, 17'h0);
    push_query(FRAC_ONE, 32'h0);
    push_query(17'h1FFFF, 32'h0);
    push_query(17'd65537, 32'h0);
    push_query(17'd1, 32'h0);
    push_query(17'd32768, 32'h0);
    push_query(17'd65535, 32'h0);
    push_add(32'h3, 17'h0);
    push_add(32'h4, 17'h0);
    push_add(32'h0, 17'h0);
    push_query(17'd49152, 32'h0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(9))
          0:       frac = '0;
          1:       frac = FRAC_ONE;
          2:       frac = FRAC_W'($urandom_range(131071, 65537));
          default: frac = FRAC_W'($urandom_range(65536));
        endcase
        push_query(frac, $urandom);
      end else begin
        // Mostly spread samples evenly over buckets so that every bucket fills.
        case ($urandom_range(9))
          0:       ns = '0;
          1:       ns = ($urandom_range(1) != 0) ? '1 : 32'h1;
          2, 3:    ns = $urandom;
          default: begin
            bin = $urandom_range(NUM_BUCKETS - 1);
            ns  = (32'h1 << bin) | ($urandom & ((32'h1 << bin) - 1));
          end
        endcase
        push_add(ns, FRAC_W'($urandom_range(131071)));
      end
    end

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while ((pending_items.size() != 0 || in_tvalid || expected_stats.size() != 0) &&
           quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display("Covered %0d sample adds and %0d percentile queries (%0d on a filled histogram),",
               add_count, query_count, hit_queries);
      $display("with %0d results checked under random valid and ready gaps.", checked);
      if (error_count == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule
